FILE: hw/rtl/gcd_pkg.sv
// shared constants, types and helper functions of the great-circle distance block
package gcd_pkg;

   // default iteration count of both cordic units
   localparam int CORDIC_STEPS_DEF = 32;
   // depth of the queue between the trig front and the arc cosine back
   localparam int QUEUE_DEPTH_DEF  = 4;

   // field widths
   localparam int LAT_W    = 28;
   localparam int LON_W    = 29;
   localparam int DIST_W   = 26;
   localparam int RADIUS_W = 24;
   localparam int REQ_W    = 120;
   localparam int RSP_W    = 32;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_RADIUS = '0;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6378000);

   // internal widths
   localparam int ANG_W   = 30;   // microdegrees, also the longitude difference
   localparam int MAG_W   = 27;   // folded magnitude, at most a quarter turn
   localparam int Z_W     = 33;   // rotation angle, q30 radians
   localparam int XY_W    = 34;   // cordic vector components
   localparam int TRIG_W  = 32;   // sine, cosine and products, q30
   localparam int C_W     = 32;   // clamped cosine sum, q30
   localparam int SQ_W    = 62;   // square root operand and partial root
   localparam int VZ_W    = 34;   // vectoring angle accumulator
   localparam int ANGLE_W = 32;   // central angle, unsigned q30
   localparam int PROD_W  = ANGLE_W + RADIUS_W;
   localparam int SQRT_STEPS = 31;

   // angle constants in microdegrees
   localparam longint HALF_UDEG    = 180 * 1000000;
   localparam longint QUARTER_UDEG = HALF_UDEG / 2;
   localparam longint FULL_UDEG    = 2 * HALF_UDEG;

   // microdegrees to q30 radians, scale pi/180e6 * 2^58, split in two partial products
   localparam longint UDEG_RAD_Q58 = 64'd5030569068;
   localparam int     K_LO_W       = 16;
   localparam longint UDEG_RAD_HI  = UDEG_RAD_Q58 >> K_LO_W;
   localparam longint UDEG_RAD_LO  = UDEG_RAD_Q58 & ((64'd1 << K_LO_W) - 1);
   localparam int     K_HI_W       = $clog2(UDEG_RAD_HI + 1);
   localparam int     SUM_W        = MAG_W + K_HI_W + K_LO_W + 1;

   // q30 constants
   localparam longint CORDIC_GAIN_Q30 = 652032874;
   localparam longint PI_Q30          = 64'd3373259426;
   localparam longint HALF_PI_Q30     = 1686629713;
   localparam longint ONE_Q30         = 1073741824;

   // queue write side and queue status
   typedef struct packed {
      logic                  vld;
      logic signed [C_W-1:0] data;
   } cq_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cq_stat_type;

   // arc tangent of 2^-i in q30
   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] r;
      case (i)
         0: r = 32'h3243F6A9;
         1: r = 32'h1DAC6705;
         2: r = 32'h0FADBAFD;
         3: r = 32'h07F56EA7;
         4: r = 32'h03FEAB77;
         5: r = 32'h01FFD55C;
         6: r = 32'h00FFFAAB;
         7: r = 32'h007FFF55;
         8: r = 32'h003FFFEB;
         9: r = 32'h001FFFFD;
         default: begin
            if (i <= 30) r = 32'(64'd1 << (30 - i));
            else r = '0;
         end
      endcase
      return r;
   endfunction

   // q30 product, round half up
   function automatic logic signed [TRIG_W-1:0] mul_q30(input logic signed [TRIG_W-1:0] a,
                                                        input logic signed [TRIG_W-1:0] b);
      logic signed [2*TRIG_W-1:0] p;
      p = a * b;
      p = p + (64'sd1 <<< 29);
      return TRIG_W'(p >>> 30);
   endfunction

endpackage

FILE: hw/rtl/gcd_rot.sv
// pipelined rotation-mode cordic, one stage per iteration, gives sine and cosine
module gcd_rot import gcd_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [Z_W-1:0]    angle_z,
   input  logic                     flip,
   output logic signed [TRIG_W-1:0] sin_out,
   output logic signed [TRIG_W-1:0] cos_out
);

   logic signed [XY_W-1:0] x_ff    [1:STEPS];
   logic signed [XY_W-1:0] y_ff    [1:STEPS];
   logic signed [Z_W-1:0]  z_ff    [1:STEPS];
   logic                   flip_ff [1:STEPS];

   genvar i;
   for (i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(atan_q30(i));
      logic signed [XY_W-1:0] x_cur, y_cur, x_in, y_in;
      logic signed [Z_W-1:0]  z_cur, z_in;
      logic                   f_cur;

      // first stage starts from the pre-scaled unit vector
      if (i == 0) begin : g_first
         assign x_cur = XY_W'(CORDIC_GAIN_Q30);
         assign y_cur = '0;
         assign z_cur = angle_z;
         assign f_cur = flip;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign z_cur = z_ff[i];
         assign f_cur = flip_ff[i];
      end

      // rotate toward zero residual angle
      always_comb begin
         if (!z_cur[Z_W-1]) begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - ATAN_I;
         end else begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= f_cur;
         end
      end
   end

   // cosine is negated for angles folded from beyond a quarter turn
   assign sin_out = TRIG_W'(y_ff[STEPS]);
   assign cos_out = flip_ff[STEPS] ? -TRIG_W'(x_ff[STEPS]) : TRIG_W'(x_ff[STEPS]);

endmodule

FILE: hw/rtl/gcd_front.sv
// front pipeline: angle reduction, radian conversion, three cordic lanes, cosine sum
module gcd_front import gcd_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   output logic                    in_rdy,
   input  logic signed [LAT_W-1:0] lat_a,
   input  logic signed [LON_W-1:0] lon_a,
   input  logic signed [LAT_W-1:0] lat_b,
   input  logic signed [LON_W-1:0] lon_b,
   output cq_push_type             push,
   input  cq_stat_type             stat
);

   localparam int LAST = STEPS + 7;
   localparam int LANES = 3;
   localparam logic signed [ANG_W-1:0] HALF_A    = ANG_W'(HALF_UDEG);
   localparam logic signed [ANG_W-1:0] QUARTER_A = ANG_W'(QUARTER_UDEG);
   localparam logic signed [ANG_W-1:0] FULL_A    = ANG_W'(FULL_UDEG);
   localparam logic [K_HI_W-1:0] K_HI = K_HI_W'(UDEG_RAD_HI);
   localparam logic [K_LO_W-1:0] K_LO = K_LO_W'(UDEG_RAD_LO);
   localparam logic [SUM_W-1:0]  RND27 = SUM_W'(64'd1 << 27);
   localparam logic signed [C_W:0] ONE_S = (C_W+1)'(ONE_Q30);

   logic                   en;
   logic [LAST:0]          vld_ff, vld_in;
   logic signed [ANG_W-1:0] ang_ff  [LANES];
   logic signed [ANG_W-1:0] wrap_ff [LANES];
   logic [MAG_W-1:0]        mag_ff  [LANES];
   logic                    neg3_ff [LANES];
   logic                    flp3_ff [LANES];
   logic [MAG_W+K_HI_W-1:0] phi_ff  [LANES];
   logic [MAG_W+K_LO_W-1:0] plo_ff  [LANES];
   logic                    neg4_ff [LANES];
   logic                    flp4_ff [LANES];
   logic signed [Z_W-1:0]   z_ff    [LANES];
   logic                    flp5_ff [LANES];
   logic signed [TRIG_W-1:0] sin_w  [LANES];
   logic signed [TRIG_W-1:0] cos_w  [LANES];
   logic signed [TRIG_W-1:0] pss_ff, pcc_ff, cd_ff, pss2_ff, pccd_ff;
   logic signed [C_W-1:0]    c_ff, c_in;
   logic signed [C_W:0]      sum_w;

   // the whole front moves unless its finished item cannot enter the queue
   assign en     = !(vld_ff[LAST] && stat.full);
   assign in_rdy = en;
   assign vld_in = {vld_ff[LAST-1:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // capture the three angles: both latitudes and the longitude difference
   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff[0] <= {{(ANG_W-LAT_W){lat_a[LAT_W-1]}}, lat_a};
         ang_ff[1] <= {{(ANG_W-LAT_W){lat_b[LAT_W-1]}}, lat_b};
         ang_ff[2] <= {lon_b[LON_W-1], lon_b} - {lon_a[LON_W-1], lon_a};
      end
   end

   genvar l;
   for (l = 0; l < LANES; l++) begin : g_lane
      logic signed [ANG_W-1:0] wrap_in, fold_w, abs_w;
      logic                    flp_w, neg_w;
      logic [SUM_W-1:0]        sum_l;
      logic [Z_W-1:0]          q_w;

      // wrap into a half-open half turn on either side
      always_comb begin
         if (ang_ff[l] > HALF_A) wrap_in = ang_ff[l] - FULL_A;
         else if (ang_ff[l] <= -HALF_A) wrap_in = ang_ff[l] + FULL_A;
         else wrap_in = ang_ff[l];
      end

      // fold into a quarter turn, keep sign and magnitude
      always_comb begin
         flp_w = 1'b0;
         if (wrap_ff[l] > QUARTER_A) begin
            fold_w = HALF_A - wrap_ff[l];
            flp_w  = 1'b1;
         end else if (wrap_ff[l] < -QUARTER_A) begin
            fold_w = -HALF_A - wrap_ff[l];
            flp_w  = 1'b1;
         end else begin
            fold_w = wrap_ff[l];
         end
         neg_w = fold_w[ANG_W-1];
         abs_w = neg_w ? -fold_w : fold_w;
      end

      // recombine partial products, round and apply the sign
      always_comb begin
         sum_l = {phi_ff[l], {K_LO_W{1'b0}}} + SUM_W'(plo_ff[l]) + RND27;
         q_w   = Z_W'(sum_l >> 28);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            wrap_ff[l] <= wrap_in;
            mag_ff[l]  <= abs_w[MAG_W-1:0];
            neg3_ff[l] <= neg_w;
            flp3_ff[l] <= flp_w;
            phi_ff[l]  <= mag_ff[l] * K_HI;
            plo_ff[l]  <= mag_ff[l] * K_LO;
            neg4_ff[l] <= neg3_ff[l];
            flp4_ff[l] <= flp3_ff[l];
            z_ff[l]    <= neg4_ff[l] ? -signed'(q_w) : signed'(q_w);
            flp5_ff[l] <= flp4_ff[l];
         end
      end

      gcd_rot #(.STEPS(STEPS)) u_rot (
         .clock   (clock),
         .en      (en),
         .angle_z (z_ff[l]),
         .flip    (flp5_ff[l]),
         .sin_out (sin_w[l]),
         .cos_out (cos_w[l])
      );
   end

   // cosine sum sin(a)sin(b) + cos(a)cos(b)cos(d), clamped to plus or minus one
   always_comb begin
      sum_w = {pss2_ff[TRIG_W-1], pss2_ff} + {pccd_ff[TRIG_W-1], pccd_ff};
      if (sum_w > ONE_S) c_in = C_W'(ONE_S);
      else if (sum_w < -ONE_S) c_in = C_W'(-ONE_S);
      else c_in = C_W'(sum_w);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pss_ff  <= mul_q30(sin_w[0], sin_w[1]);
         pcc_ff  <= mul_q30(cos_w[0], cos_w[1]);
         cd_ff   <= cos_w[2];
         pss2_ff <= pss_ff;
         pccd_ff <= mul_q30(pcc_ff, cd_ff);
         c_ff    <= c_in;
      end
   end

   assign push.vld  = vld_ff[LAST];
   assign push.data = c_ff;

endmodule

FILE: hw/rtl/gcd_fifo.sv
// short queue of cosine sums between the front and the back pipelines
module gcd_fifo import gcd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cq_push_type           push,
   input  logic                  pop,
   output logic signed [C_W-1:0] pop_data,
   output cq_stat_type           stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic signed [C_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             wr_en, rd_en;

   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign wr_en      = push.vld && !stat.full;
   assign rd_en      = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (wr_en) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      if (rd_en) rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      if (wr_en && !rd_en) cnt_in = cnt_ff + 1'b1;
      else if (rd_en && !wr_en) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ff] <= push.data;
   end

endmodule

FILE: hw/rtl/gcd_back.sv
// back pipeline: square root, vectoring cordic arc cosine, radius scaling, output register
module gcd_back import gcd_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cq_stat_type             stat,
   input  logic signed [C_W-1:0]   pop_data,
   output logic                    pop,
   input  logic [RADIUS_W-1:0]     radius,
   output logic                    out_vld,
   input  logic                    out_rdy,
   output logic [DIST_W-1:0]       dist_out
);

   localparam int LAST = SQRT_STEPS + STEPS + 6;
   localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(64'd1 << 60);
   localparam logic signed [VZ_W-1:0] HALF_PI_Z = VZ_W'(HALF_PI_Q30);
   localparam logic signed [VZ_W-1:0] PI_Z      = VZ_W'(PI_Q30);
   localparam logic [PROD_W:0] RND29 = (PROD_W+1)'(64'd1 << 29);
   localparam logic [PROD_W-30:0] DIST_MAX_W = (PROD_W-29)'({DIST_W{1'b1}});

   logic                    en;
   logic [LAST:0]           vld_ff;
   logic signed [C_W-1:0]   c1_ff, c2_ff, c3_ff;
   logic [SQ_W-1:0]         cc_ff, n0_ff;
   logic signed [2*C_W-1:0] sq_w;
   logic [SQ_W-1:0]         n_ff   [1:SQRT_STEPS];
   logic [SQ_W-1:0]         res_ff [1:SQRT_STEPS];
   logic signed [C_W-1:0]   cs_ff  [1:SQRT_STEPS];
   logic signed [XY_W-1:0]  x0_ff, y0_ff;
   logic signed [VZ_W-1:0]  z0_ff;
   logic signed [XY_W-1:0]  vx_ff  [1:STEPS];
   logic signed [XY_W-1:0]  vy_ff  [1:STEPS];
   logic signed [VZ_W-1:0]  vz_ff  [1:STEPS];
   logic [ANGLE_W-1:0]      ang_ff, ang_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [PROD_W:0]         rnd_w;
   logic [PROD_W-30:0]      q_w;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   logic signed [C_W-1:0]   c_last;
   logic [SQ_W-1:0]         root_w;

   // the back moves whenever its output register is free or being taken
   assign en       = !vld_ff[LAST] || out_rdy;
   assign pop      = en && !stat.empty;
   assign out_vld  = vld_ff[LAST];
   assign dist_out = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAST-1:0], !stat.empty};
      end
   end

   // 1 - c*c as the square root operand
   assign sq_w = c1_ff * c1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= pop_data;
         c2_ff <= c1_ff;
         cc_ff <= SQ_W'(sq_w);
         c3_ff <= c2_ff;
         n0_ff <= ONE_SQ - cc_ff;
      end
   end

   // restoring integer square root, one result bit per stage
   genvar k;
   for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT_K = SQ_W'(64'd1 << (2 * (SQRT_STEPS - 1 - k)));
      logic [SQ_W-1:0]       n_cur, r_cur, t_w, n_in, res_in;
      logic signed [C_W-1:0] c_cur;

      if (k == 0) begin : g_first
         assign n_cur = n0_ff;
         assign r_cur = '0;
         assign c_cur = c3_ff;
      end else begin : g_next
         assign n_cur = n_ff[k];
         assign r_cur = res_ff[k];
         assign c_cur = cs_ff[k];
      end

      always_comb begin
         t_w = r_cur + BIT_K;
         if (n_cur >= t_w) begin
            n_in   = n_cur - t_w;
            res_in = (r_cur >> 1) + BIT_K;
         end else begin
            n_in   = n_cur;
            res_in = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k+1]   <= n_in;
            res_ff[k+1] <= res_in;
            cs_ff[k+1]  <= c_cur;
         end
      end
   end

   // start vector (c, root), turned a quarter for negative c
   assign c_last = cs_ff[SQRT_STEPS];
   assign root_w = res_ff[SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         if (c_last[C_W-1]) begin
            x0_ff <= XY_W'(root_w);
            y0_ff <= -{{(XY_W-C_W){c_last[C_W-1]}}, c_last};
            z0_ff <= HALF_PI_Z;
         end else begin
            x0_ff <= {{(XY_W-C_W){1'b0}}, c_last};
            y0_ff <= XY_W'(root_w);
            z0_ff <= '0;
         end
      end
   end

   // vectoring cordic: drive y to zero, accumulate the angle
   genvar i;
   for (i = 0; i < STEPS; i++) begin : g_vec
      localparam logic signed [VZ_W-1:0] ATAN_I = VZ_W'(atan_q30(i));
      logic signed [XY_W-1:0] x_cur, y_cur, x_in, y_in;
      logic signed [VZ_W-1:0] z_cur, z_in;

      if (i == 0) begin : g_first
         assign x_cur = x0_ff;
         assign y_cur = y0_ff;
         assign z_cur = z0_ff;
      end else begin : g_next
         assign x_cur = vx_ff[i];
         assign y_cur = vy_ff[i];
         assign z_cur = vz_ff[i];
      end

      always_comb begin
         if (!y_cur[XY_W-1]) begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + ATAN_I;
         end else begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vx_ff[i+1] <= x_in;
            vy_ff[i+1] <= y_in;
            vz_ff[i+1] <= z_in;
         end
      end
   end

   // clamp the angle to [0, pi]
   always_comb begin
      if (vz_ff[STEPS][VZ_W-1]) ang_in = '0;
      else if (vz_ff[STEPS] > PI_Z) ang_in = ANGLE_W'(PI_Z);
      else ang_in = ANGLE_W'(vz_ff[STEPS]);
   end

   // scale by the radius, round to metres, saturate
   always_comb begin
      rnd_w = {1'b0, prod_ff} + RND29;
      q_w   = rnd_w[PROD_W:29+1];
      if (q_w > DIST_MAX_W) dist_in = '1;
      else dist_in = DIST_W'(q_w);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff  <= ang_in;
         prod_ff <= ang_ff * radius;
         dist_ff <= dist_in;
      end
   end

endmodule

FILE: hw/rtl/great_circle_distance.sv
// top level of the great-circle distance block: stream ports, radius register, front, queue, back
//
// Takes a pair of points (latitude and longitude in signed microdegrees) per request and returns
// the spherical law of cosines distance in whole metres on a sphere whose radius is set in the
// radius register (byte address 0, reset 6378000 m). Any bit pattern of the angles is reduced
// modulo a full turn. The block takes one request every clock cycle unless a full queue holds
// the front; requests are fully independent. Latency from acceptance to the result being offered
// is set by the two cordic pipelines of CORDIC_STEPS stages each and the 31-stage square root;
// the front and the back are parted by a QUEUE_DEPTH entry queue so that a stalled result side
// holds the back while the front keeps filling the queue.
module great_circle_distance import gcd_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: first_latitude, first_longitude, second_latitude, second_longitude, zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // result: distance_m, zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [RADIUS_W-1:0]   radius_ff;
   logic                  csr_wr;
   cq_push_type           cq_push;
   cq_stat_type           cq_stat;
   logic                  cq_pop;
   logic signed [C_W-1:0] cq_data;
   logic [DIST_W-1:0]     dist_w;

   // radius register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1:2] == REG_RADIUS);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_RADIUS) ?
                       CSR_DATA_W'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr) begin
         radius_ff <= csr_pwdata[RADIUS_W-1:0];
      end
   end

   gcd_front #(.STEPS(CORDIC_STEPS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .in_vld (req_tvalid),
      .in_rdy (req_tready),
      .lat_a  (req_tdata[LAT_W-1:0]),
      .lon_a  (req_tdata[LAT_W+LON_W-1:LAT_W]),
      .lat_b  (req_tdata[2*LAT_W+LON_W-1:LAT_W+LON_W]),
      .lon_b  (req_tdata[2*LAT_W+2*LON_W-1:2*LAT_W+LON_W]),
      .push   (cq_push),
      .stat   (cq_stat)
   );

   gcd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cq_push),
      .pop      (cq_pop),
      .pop_data (cq_data),
      .stat     (cq_stat)
   );

   gcd_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .stat     (cq_stat),
      .pop_data (cq_data),
      .pop      (cq_pop),
      .radius   (radius_ff),
      .out_vld  (rsp_tvalid),
      .out_rdy  (rsp_tready),
      .dist_out (dist_w)
   );

   assign rsp_tdata = RSP_W'(dist_w);

   // a full queue with a finished front item must hold off new requests
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      cq_push.vld && cq_stat.full |-> !req_tready)
      else $error("request taken while the front is blocked by a full queue");

   // the back never takes from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cq_pop |-> !cq_stat.empty)
      else $error("queue read while empty");

   // a radius write lands in the register
   a_radius_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> radius_ff == $past(csr_pwdata[RADIUS_W-1:0]))
      else $error("radius register not updated by write");

endmodule

FILE: test/testbench.sv
// stream testbench of the great-circle distance block with its own fixed-point distance predictor
module testbench;
   import gcd_pkg::*;

   typedef struct {
      logic [LAT_W-1:0] lat_a;
      logic [LON_W-1:0] lon_a;
      logic [LAT_W-1:0] lat_b;
      logic [LON_W-1:0] lon_b;
   } point_pair_type;

   localparam int SETTLE_CYCLES = 2 * CORDIC_STEPS_DEF + 47 + 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   point_pair_type    pending_pairs[$];
   logic [DIST_W-1:0] expected_dist[$];
   longint            radius_m;
   int                error_count = 0;
   int                send_gap = 0;
   int                recv_gap = 0;
   bit                recv_hold;
   bit                hold_start = 1'b0;
   bit                quiet_send = 1'b0;
   bit                quiet_recv = 1'b0;
   logic              req_taken;

   great_circle_distance u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // arc tangent of 2^-i in q30
   function automatic longint atan_step(input int i);
      longint head[10];
      head = '{64'h3243F6A9, 64'h1DAC6705, 64'h0FADBAFD, 64'h07F56EA7, 64'h03FEAB77,
               64'h01FFD55C, 64'h00FFFAAB, 64'h007FFF55, 64'h003FFFEB, 64'h001FFFFD};
      if (i < 10) return head[i];
      if (i <= 30) return 64'sd1 <<< (30 - i);
      return 0;
   endfunction

   // sine and cosine in q30 of an angle in microdegrees
   function automatic void trig_of_udeg(input longint udeg, output longint sn,
                                        output longint cs);
      longint half;
      longint quarter;
      longint r;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint unsigned mag;
      bit flip;
      bit neg;
      half = HALF_UDEG;
      quarter = QUARTER_UDEG;
      flip = 1'b0;
      r = udeg % (2 * half);
      if (r > half) r -= 2 * half;
      if (r <= -half) r += 2 * half;
      // fold into a quarter turn, cosine changes sign
      if (r > quarter) begin
         r = half - r;
         flip = 1'b1;
      end else if (r < -quarter) begin
         r = -half - r;
         flip = 1'b1;
      end
      neg = r < 0;
      mag = neg ? -r : r;
      mag = (mag * UDEG_RAD_Q58 + (64'd1 << 27)) >> 28;
      z = neg ? -longint'(mag) : longint'(mag);
      x = CORDIC_GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      sn = y;
      cs = flip ? -x : x;
   endfunction

   function automatic longint q30_product(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // central angle in q30 from the clamped cosine sum, vectoring cordic
   function automatic longint central_angle(input longint c);
      longint x;
      longint y;
      longint z;
      longint t;
      longint dx;
      longint dy;
      x = c;
      z = 0;
      y = longint'(floor_root(longint'(ONE_Q30 * ONE_Q30 - c * c)));
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = HALF_PI_Q30;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      if (z < 0) z = 0;
      if (z > PI_Q30) z = PI_Q30;
      return z;
   endfunction

   function automatic logic [DIST_W-1:0] distance_of(input point_pair_type p, input longint rad);
      longint sa, ca, sb, cb, sd, cd, c, ang;
      longint unsigned dist_val;
      trig_of_udeg(longint'($signed(p.lat_a)), sa, ca);
      trig_of_udeg(longint'($signed(p.lat_b)), sb, cb);
      trig_of_udeg(longint'($signed(p.lon_b)) - longint'($signed(p.lon_a)), sd, cd);
      c = q30_product(sa, sb) + q30_product(q30_product(ca, cb), cd);
      if (c > ONE_Q30) c = ONE_Q30;
      if (c < -ONE_Q30) c = -ONE_Q30;
      ang = central_angle(c);
      dist_val = (unsigned'(ang) * unsigned'(rad) + (64'd1 << 29)) >> 30;
      if (dist_val > (64'd1 << DIST_W) - 1) dist_val = (64'd1 << DIST_W) - 1;
      return DIST_W'(dist_val);
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver
   always @(negedge clock) begin
      point_pair_type p;
      logic        next_valid;
      logic [REQ_W-1:0] next_data;
      next_valid = req_tvalid;
      next_data = req_tdata;
      if (!reset && !(req_tvalid && !req_taken)) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_pairs.size() > 0) begin
            p = pending_pairs.pop_front();
            next_data = '0;
            next_data[LAT_W-1:0] = p.lat_a;
            next_data[LAT_W +: LON_W] = p.lon_a;
            next_data[LAT_W+LON_W +: LAT_W] = p.lat_b;
            next_data[2*LAT_W+LON_W +: LON_W] = p.lon_b;
            next_valid = 1'b1;
            send_gap = pick_gap(quiet_send);
            if ($urandom_range(0, 99) == 0) quiet_send = !quiet_send;
         end
      end
      req_tvalid <= next_valid;
      req_tdata <= next_data;
   end

   // request acceptance and prediction
   always @(posedge clock) begin
      point_pair_type p;
      if (!reset && req_tvalid && req_tready) begin
         p.lat_a = req_tdata[LAT_W-1:0];
         p.lon_a = req_tdata[LAT_W +: LON_W];
         p.lat_b = req_tdata[LAT_W+LON_W +: LAT_W];
         p.lon_b = req_tdata[2*LAT_W+LON_W +: LON_W];
         expected_dist = {expected_dist, distance_of(p, radius_m)};
      end
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // long hold-off on the result side, counted in cycles
   initial begin
      recv_hold = 1'b0;
      wait (hold_start);
      recv_hold = 1'b1;
      repeat (400) @(negedge clock);
      recv_hold = 1'b0;
   end

   // result ready with random stalls
   always @(negedge clock) begin
      logic next_ready;
      next_ready = 1'b1;
      if (reset) begin
         next_ready = 1'b0;
      end else if (recv_hold) begin
         next_ready = 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         next_ready = 1'b0;
      end else begin
         recv_gap = pick_gap(quiet_recv);
         if ($urandom_range(0, 99) == 0) quiet_recv = !quiet_recv;
      end
      rsp_tready <= next_ready;
   end

   // result check
   always @(posedge clock) begin
      logic [DIST_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_dist.size() == 0) begin
            $error("distance_m: unexpected result %0d", rsp_tdata[DIST_W-1:0]);
            error_count++;
         end else begin
            want = expected_dist.pop_front();
            if (rsp_tdata[DIST_W-1:0] !== want) begin
               $error("distance_m: expected %0d, actual %0d", want, rsp_tdata[DIST_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[RSP_W-1:DIST_W] !== '0) begin
               $error("rsp_tdata fill: expected 0, actual %0h", rsp_tdata[RSP_W-1:DIST_W]);
               error_count++;
            end
         end
      end
   end

   task automatic write_radius(input longint value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({REG_RADIUS, 2'b00});
      csr_pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      radius_m = value & 64'hFFFFFF;
   endtask

   task automatic queue_pair(input longint la, input longint oa, input longint lb,
                             input longint ob);
      point_pair_type p;
      p.lat_a = LAT_W'(la);
      p.lon_a = LON_W'(oa);
      p.lat_b = LAT_W'(lb);
      p.lon_b = LON_W'(ob);
      pending_pairs = {pending_pairs, p};
   endtask

   // random pairs: mostly in range, some raw bit patterns
   task automatic queue_random(input int count);
      point_pair_type p;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            p.lat_a = LAT_W'($urandom);
            p.lon_a = LON_W'($urandom);
            p.lat_b = LAT_W'($urandom);
            p.lon_b = LON_W'($urandom);
            pending_pairs = {pending_pairs, p};
         end else begin
            queue_pair(longint'($urandom_range(0, 180000000)) - 90000000,
                       longint'($urandom_range(0, 360000000)) - 180000000,
                       longint'($urandom_range(0, 180000000)) - 90000000,
                       longint'($urandom_range(0, 360000000)) - 180000000);
         end
      end
   endtask

   // wait until every request has been sent and its result checked
   task automatic drain;
      do @(posedge clock);
      while (pending_pairs.size() != 0 || req_tvalid || expected_dist.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus and end of run
   initial begin
      longint radii[4];
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      radius_m = RADIUS_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, same point, antipodes, poles, raw patterns
      queue_pair(0, 0, 0, 0);
      queue_pair(90000000, 0, -90000000, 0);
      queue_pair(-90000000, -180000000, 90000000, 180000000);
      queue_pair(0, -180000000, 0, 180000000);
      queue_pair(0, 0, 0, 180000000);
      queue_pair(0, -90000000, 0, 90000000);
      queue_pair(45000000, 10000000, 45000000, 10000000);
      queue_pair(48856600, 2352200, 40712800, -74006000);
      queue_pair(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
      queue_pair((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28));
      queue_pair(-1, -1, -1, -1);
      queue_pair(1, 0, 0, 1);
      queue_pair(90000000, 123456789, 90000000, -98765432);
      queue_pair(0, 0, 0, 1);
      queue_pair(30000000, 0, -30000000, 179999999);
      queue_random(220);
      // long hold-off on the result side while requests keep coming
      hold_start = 1'b1;
      drain();

      radii = '{1, 16777215, 0, 0};
      radii[3] = $urandom_range(1, 16777215);
      foreach (radii[k]) begin
         write_radius(radii[k]);
         queue_pair(0, 0, 0, 180000000);
         queue_pair(90000000, 0, -90000000, 0);
         queue_random(115);
         drain();
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_rot.sv
hw/rtl/gcd_front.sv
hw/rtl/gcd_fifo.sv
hw/rtl/gcd_back.sv
hw/rtl/great_circle_distance.sv
test/testbench.sv
